// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes shared by the bounded deque with search: request and
// result beats, operation and status codes, cell control and sequencer state.
// ----------------------------------------------------------------------------
package bdq_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_SIZE      = 3'd5
  } bdq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } bdq_status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } bdq_state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } bdq_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] match_position;
    logic [4:0] entry_count;
  } bdq_out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic shift_left;
    logic shift_right;
  } bdq_cell_ctrl_t;

endpackage

// ===== rtl/core/bounded_deque_with_search_core.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Bounded deque of signed 32-bit values with front/back insert and remove,
// value search and size query.
//
// Usage: a request beat (operation, value) enters on in_valid_i/in_stall_o;
// each request yields exactly one result beat (status, match_position,
// entry_count) on out_valid_o/out_stall_i. Entries live in a ring of CAPACITY
// cells, front at cell 0. For inserts, removes and size requests the result
// is valid the cycle after the request beat, and the next request may enter
// then. A search rotates the whole ring once through the head-cell comparator,
// one entry per cycle, and no new request is taken until its result has been
// registered. A finished result waits in an output register; a new request
// is taken while that register is free or drains in the same cycle, so a
// stalled receiver holds off further requests.
// Reset empties the deque and clears the result valid; no clearing pass
// is needed, the block accepts requests right after reset.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core #(
  parameter int CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bdq_pkg::bdq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bdq_pkg::bdq_out_t out_data_o
);

  bdq_pkg::bdq_cell_ctrl_t cell_ctrl;
  logic [CAPACITY-1:0]     load_en;
  logic signed [31:0]      cell_data [CAPACITY];

  bdq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .head_data_i (cell_data[0]),
    .cell_ctrl_o (cell_ctrl),
    .load_en_o   (load_en)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bdq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .load_i       (load_en[i]),
      .load_data_i  (in_data_i.value),
      .left_data_i  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
      .right_data_i (cell_data[(i + 1) % CAPACITY]),
      .data_o       (cell_data[i])
    );
  end

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == bdq_pkg::ST_FULL)
      |-> out_data_o.entry_count == 5'(CAPACITY))
    else $error("full status with count below capacity");

  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == bdq_pkg::ST_EMPTY)
      |-> out_data_o.entry_count == 5'd0)
    else $error("empty status with nonzero count");

  a_miss_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == bdq_pkg::ST_NOT_FOUND)
      |-> out_data_o.match_position == 4'd0)
    else $error("not-found result with nonzero position");

  a_quick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation != bdq_pkg::OP_SEARCH)
      |=> out_valid_o)
    else $error("single-cycle request produced no result beat");

endmodule

// ===== rtl/core/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque chain. Holds one entry and takes the entry of
// its left or right neighbor on a shift, or a new value on a load.
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic                    clk_i,
  input  bdq_pkg::bdq_cell_ctrl_t ctrl_i,
  input  logic                    load_i,
  input  logic signed [31:0]      load_data_i,
  input  logic signed [31:0]      left_data_i,
  input  logic signed [31:0]      right_data_i,
  output logic signed [31:0]      data_o
);

  logic signed [31:0] data_q;
  logic signed [31:0] data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift_left) begin
      data_d = right_data_i;
    end else if (ctrl_i.shift_right) begin
      data_d = left_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer of the deque. Keeps the entry count, drives the cell chain and
// runs a search as one full rotation of the chain, comparing the head cell.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  bdq_pkg::bdq_in_t        in_data_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output bdq_pkg::bdq_out_t       out_data_o,
  input  logic signed [31:0]      head_data_i,
  output bdq_pkg::bdq_cell_ctrl_t cell_ctrl_o,
  output logic [CAPACITY-1:0]     load_en_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  bdq_pkg::bdq_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       step_q, step_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic                found_q, found_d;
  logic signed [31:0]  key_q, key_d;
  logic                out_valid_q, out_valid_d;
  bdq_pkg::bdq_out_t   out_data_q, out_data_d;

  logic          accept;
  logic          full;
  logic          empty;
  logic          hit;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;

  assign in_stall_o = (state_q == bdq_pkg::S_SEARCH) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign count_inc  = count_q + CW'(1);
  assign count_dec  = count_q - CW'(1);
  // entry at position step sits in the head cell during the rotation
  assign hit        = (head_data_i == key_q) && (CW'(step_q) < count_q) && !found_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    pos_d       = pos_q;
    found_d     = found_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    cell_ctrl_o = '0;
    load_en_o   = '0;

    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = bdq_pkg::ST_OK;
          out_data_d.match_position  = '0;
          out_data_d.entry_count     = 5'(count_q);
          case (bdq_pkg::bdq_op_e'(in_data_i.operation))
            bdq_pkg::OP_INS_FRONT: begin
              if (full) begin
                out_data_d.status = bdq_pkg::ST_FULL;
              end else begin
                cell_ctrl_o.shift_right = 1'b1;
                load_en_o[0]            = 1'b1;
                count_d                 = count_inc;
                out_data_d.entry_count  = 5'(count_inc);
              end
            end
            bdq_pkg::OP_INS_BACK: begin
              if (full) begin
                out_data_d.status = bdq_pkg::ST_FULL;
              end else begin
                load_en_o              = CAPACITY'(1) << count_q[IW-1:0];
                count_d                = count_inc;
                out_data_d.entry_count = 5'(count_inc);
              end
            end
            bdq_pkg::OP_REM_FRONT: begin
              if (empty) begin
                out_data_d.status = bdq_pkg::ST_EMPTY;
              end else begin
                cell_ctrl_o.shift_left = 1'b1;
                count_d                = count_dec;
                out_data_d.entry_count = 5'(count_dec);
              end
            end
            bdq_pkg::OP_REM_BACK: begin
              if (empty) begin
                out_data_d.status = bdq_pkg::ST_EMPTY;
              end else begin
                count_d                = count_dec;
                out_data_d.entry_count = 5'(count_dec);
              end
            end
            bdq_pkg::OP_SEARCH: begin
              out_valid_d = 1'b0;
              state_d     = bdq_pkg::S_SEARCH;
              step_d      = '0;
              pos_d       = '0;
              found_d     = 1'b0;
              key_d       = in_data_i.value;
            end
            default: begin
            end
          endcase
        end
      end
      bdq_pkg::S_SEARCH: begin
        // a full turn of the ring leaves the chain in its original order
        cell_ctrl_o.shift_left = 1'b1;
        step_d                 = step_q + IW'(1);
        if (hit) begin
          found_d = 1'b1;
          pos_d   = step_q;
        end
        if (step_q == IW'(CAPACITY - 1)) begin
          state_d                   = bdq_pkg::S_IDLE;
          out_valid_d               = 1'b1;
          out_data_d.status         = (found_q || hit) ? bdq_pkg::ST_OK
                                                       : bdq_pkg::ST_NOT_FOUND;
          out_data_d.match_position = 4'(hit ? step_q : pos_q);
          out_data_d.entry_count    = 5'(count_q);
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    key_q      <= key_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/sv/bounded_deque_with_search_core_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core_tb
// Self-checking bench for the bounded deque: a local deque predictor computes
// each expected response as the request beat is accepted, and a monitor
// compares every response beat in order. Directed corner cases come first,
// then biased random traffic with random idles on both sides, a long output
// hold-off and a back-to-back stretch.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core_tb;

  localparam int DEPTH = 16;
  localparam int TAIL_CYCLES = DEPTH + 8;
  localparam logic [2:0] OP_RSVD_LO = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int MODE_GROW = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED = 2;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  bdq_pkg::bdq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bdq_pkg::bdq_out_t out_data;

  // predictor state
  logic signed [31:0] dq_mem [DEPTH];
  int                 dq_front = 0;
  int                 dq_count = 0;

  bdq_pkg::bdq_out_t pending_responses[$];
  bit                no_idle = 1'b0;
  int                hold_request = 0;
  int                fail_count = 0;
  int                requests_sent = 0;
  int                responses_checked = 0;
  int                search_hits = 0;
  int                search_misses = 0;
  int                full_refusals = 0;
  int                empty_refusals = 0;

  bounded_deque_with_search_core #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // applies one request to the predicted deque and returns its response
  function automatic bdq_pkg::bdq_out_t deque_response(bdq_pkg::bdq_in_t req);
    bdq_pkg::bdq_out_t res;
    res = '0;
    res.status = bdq_pkg::ST_OK;
    case (req.operation)
      bdq_pkg::OP_INS_FRONT: begin
        if (dq_count >= DEPTH) begin
          res.status = bdq_pkg::ST_FULL;
          full_refusals++;
        end else begin
          dq_front = (dq_front + DEPTH - 1) % DEPTH;
          dq_mem[dq_front] = req.value;
          dq_count++;
        end
      end
      bdq_pkg::OP_INS_BACK: begin
        if (dq_count >= DEPTH) begin
          res.status = bdq_pkg::ST_FULL;
          full_refusals++;
        end else begin
          dq_mem[(dq_front + dq_count) % DEPTH] = req.value;
          dq_count++;
        end
      end
      bdq_pkg::OP_REM_FRONT: begin
        if (dq_count == 0) begin
          res.status = bdq_pkg::ST_EMPTY;
          empty_refusals++;
        end else begin
          dq_front = (dq_front + 1) % DEPTH;
          dq_count--;
        end
      end
      bdq_pkg::OP_REM_BACK: begin
        if (dq_count == 0) begin
          res.status = bdq_pkg::ST_EMPTY;
          empty_refusals++;
        end else begin
          dq_count--;
        end
      end
      bdq_pkg::OP_SEARCH: begin
        res.status = bdq_pkg::ST_NOT_FOUND;
        for (int i = 0; i < dq_count; i++) begin
          if (dq_mem[(dq_front + i) % DEPTH] == req.value) begin
            res.status = bdq_pkg::ST_OK;
            res.match_position = 4'(i);
            break;
          end
        end
        if (res.status == bdq_pkg::ST_OK) search_hits++;
        else search_misses++;
      end
      default: ;
    endcase
    res.entry_count = 5'(dq_count);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      // narrow range so duplicates show up in the deque
      4, 5, 6: return 32'($urandom_range(0, 7)) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  // mostly a value that is present, so searches hit at every position
  function automatic logic signed [31:0] search_value();
    if (dq_count > 0 && $urandom_range(0, 2) != 0)
      return dq_mem[(dq_front + $urandom_range(0, dq_count - 1)) % DEPTH];
    return pick_value();
  endfunction

  function automatic logic [2:0] pick_op(int mode);
    int r;
    int ins_w;
    int rem_w;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        ins_w = 55;
        rem_w = 15;
      end
      MODE_SHRINK: begin
        ins_w = 15;
        rem_w = 55;
      end
      default: begin
        ins_w = 32;
        rem_w = 30;
      end
    endcase
    if (r < ins_w)
      return $urandom_range(0, 1) ? bdq_pkg::OP_INS_BACK : bdq_pkg::OP_INS_FRONT;
    r -= ins_w;
    if (r < rem_w)
      return $urandom_range(0, 1) ? bdq_pkg::OP_REM_BACK : bdq_pkg::OP_REM_FRONT;
    r -= rem_w;
    if (r < 3) return $urandom_range(0, 1) ? OP_RSVD_HI : OP_RSVD_LO;
    if (r < 9) return bdq_pkg::OP_SIZE;
    return bdq_pkg::OP_SEARCH;
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_beat(input logic [2:0] op, input logic signed [31:0] val);
    int               gap;
    bdq_pkg::bdq_in_t req;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    req.operation = op;
    req.value = val;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_responses.push_back(deque_response(req));
    requests_sent++;
  endtask

  task automatic send_random(int mode);
    logic [2:0] op;
    op = pick_op(mode);
    send_beat(op, (op == bdq_pkg::OP_SEARCH) ? search_value() : pick_value());
  endtask

  // sender goes quiet until every outstanding response has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic test_directed();
    send_beat(bdq_pkg::OP_REM_FRONT, 32'sd5);
    send_beat(bdq_pkg::OP_REM_BACK, -32'sd5);
    send_beat(bdq_pkg::OP_SEARCH, '0);
    send_beat(bdq_pkg::OP_SIZE, '0);
    send_beat(OP_RSVD_LO, 32'sh7fffffff);
    send_beat(OP_RSVD_HI, 32'sh80000000);
    send_beat(bdq_pkg::OP_INS_FRONT, 32'sh7fffffff);
    send_beat(bdq_pkg::OP_INS_BACK, 32'sh80000000);
    send_beat(bdq_pkg::OP_INS_FRONT, '0);
    send_beat(bdq_pkg::OP_INS_BACK, -32'sd1);
    send_beat(bdq_pkg::OP_SEARCH, 32'sh80000000);
    send_beat(bdq_pkg::OP_SEARCH, 32'sd12345);
    send_beat(OP_RSVD_HI, '0);
    for (int k = 0; k < DEPTH - 4; k++)
      send_beat(k[0] ? bdq_pkg::OP_INS_FRONT : bdq_pkg::OP_INS_BACK, $urandom());
    send_beat(bdq_pkg::OP_INS_FRONT, '0);
    send_beat(bdq_pkg::OP_INS_BACK, -32'sd1);
    send_beat(bdq_pkg::OP_SEARCH, dq_mem[(dq_front + DEPTH - 1) % DEPTH]);
    send_beat(bdq_pkg::OP_SEARCH, 32'sd12345);
    send_beat(bdq_pkg::OP_REM_FRONT, '0);
    send_beat(bdq_pkg::OP_REM_BACK, '0);
    send_beat(bdq_pkg::OP_SIZE, '0);
    drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 30; phase++) begin
      int mode;
      mode = $urandom_range(MODE_GROW, MODE_MIXED);
      repeat (46) send_random(mode);
      if (phase % 10 == 9) drain();
    end
    drain();
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_output_hold();
    hold_request = 80;
    repeat (30) send_random(MODE_MIXED);
    drain();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (120) send_random(MODE_GROW);
    repeat (120) send_random(MODE_SHRINK);
    drain();
    no_idle = 1'b0;
  endtask

  initial begin : response_monitor
    int                wait_left;
    int                hold_left;
    bit                taken;
    bdq_pkg::bdq_out_t want;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      taken = out_valid && !out_stall;
      if (taken) begin
        responses_checked++;
        if (pending_responses.size() == 0) begin
          $error("response beat with nothing expected: %p", out_data);
          fail_count++;
        end else begin
          want = pending_responses.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.match_position !== want.match_position) begin
            $error("match_position: expected %0d, got %0d",
                   want.match_position, out_data.match_position);
            fail_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_data.entry_count);
            fail_count++;
          end
        end
        wait_left = no_idle ? 0 : $urandom_range(0, 4);
      end else if (out_valid && wait_left > 0) begin
        wait_left--;
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0) || (wait_left > 0);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_output_hold();
    test_back_to_back();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d responses checked", requests_sent,
             responses_checked);
    $display("search hits %0d, misses %0d, full refusals %0d, empty refusals %0d",
             search_hits, search_misses, full_refusals, empty_refusals);
    if (fail_count == 0 && pending_responses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
